// ----- hw/rtl/mtx_pkg.sv -----
// ----------------------------------------------------------------------------
// mtx_pkg
// Shared sizes, field positions and codes of the mutex table core.
// ----------------------------------------------------------------------------
package mtx_pkg;

   localparam int MaxMutexes = 16;
   localparam int MaxThreads = 16;

   localparam int MutexW   = $clog2(MaxMutexes);
   localparam int ThreadW  = $clog2(MaxThreads);
   localparam int AllocW   = MutexW + 1;
   localparam int CmdW     = 2;
   localparam int StatusW  = 3;
   localparam int CountW   = 7;
   localparam int CountSat = 127;

   // Request word layout, lowest bit first.
   localparam int ReqFieldW = CmdW + MutexW + ThreadW;
   localparam int ReqDataW  = ((ReqFieldW + 7) / 8) * 8;

   // Response word layout, lowest bit first.
   localparam int RspStatusLo  = 0;
   localparam int RspGrantedLo = RspStatusLo + StatusW;
   localparam int RspNewLo     = RspGrantedLo + 1;
   localparam int RspCountLo   = RspNewLo + MutexW;
   localparam int RspPairALo   = RspCountLo + CountW;
   localparam int RspPairBLo   = RspPairALo + MutexW;
   localparam int RspFieldW    = RspPairBLo + MutexW;
   localparam int RspDataW     = ((RspFieldW + 7) / 8) * 8;

   typedef enum logic [CmdW-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_LOCK    = 2'd1,
      CMD_UNLOCK  = 2'd2,
      CMD_DESTROY = 2'd3
   } cmd_type;

   typedef enum logic [StatusW-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_NO_SPACE  = 3'd1,
      STATUS_NOT_OWNER = 3'd2,
      STATUS_BUSY      = 3'd3,
      STATUS_BAD_ID    = 3'd4
   } status_type;

endpackage

// ----- hw/rtl/mutex_table_with_deadlock_check_core.sv -----
// ----------------------------------------------------------------------------
// mutex_table_with_deadlock_check_core
// Lock table with create, lock, unlock and destroy commands and a pairwise
// mutual-wait scan that runs before every lock that passes the id checks.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------
//   req_    | in        | req_tvalid / req_tready  | command, mutex, thread
//   rsp_    | out       | rsp_tvalid / rsp_tready  | status, granted, new mutex,
//           |           |                          | deadlock count, first pair
//
// A word is taken on the request side only while the sequencer is idle.
// A lock on an allocated mutex walks the table one row per cycle through a
// single shared row compare unit, in a scan step that lies between the
// accept and finish steps; every other command goes from the accept step
// straight to the finish step. The response sits in an output register,
// so a new request word may be accepted while the previous response waits;
// the sequencer then holds in its finish step until the output register
// frees up. Reset is synchronous and active high; it empties the table,
// clears all waiting bits and drops the response valid.
//
module mutex_table_with_deadlock_check_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [1:0] command, [5:2] mutex_index, [9:6] thread_index, upper bits zero
   input  logic [mtx_pkg::ReqDataW-1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [2:0] status, [3] granted, [7:4] new_mutex, [14:8] deadlock_count,
   // [18:15] first_pair_a, [22:19] first_pair_b, upper bits zero
   output logic [mtx_pkg::RspDataW-1:0] rsp_tdata
);

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'b001,
      SEQ_SCAN = 3'b010,
      SEQ_DONE = 3'b100
   } seq_type;

   localparam int MW = mtx_pkg::MutexW;
   localparam int TW = mtx_pkg::ThreadW;
   localparam int NM = mtx_pkg::MaxMutexes;
   localparam int NT = mtx_pkg::MaxThreads;
   localparam int CW = mtx_pkg::CountW;
   localparam int AW = mtx_pkg::AllocW;

   // Sequencer and captured request.
   seq_type                 state_ff, state_in;
   mtx_pkg::cmd_type        cmd_ff, cmd_in;
   logic [MW-1:0]           mutex_ff, mutex_in;
   logic [TW-1:0]           thread_ff, thread_in;

   // Table state.
   logic [AW-1:0]           alloc_ff, alloc_in;
   logic [NM-1:0]           held_ff, held_in;
   logic [TW-1:0]           holder_ff [NM];
   logic [TW-1:0]           holder_in [NM];
   logic [NT-1:0]           wait_ff [NM];
   logic [NT-1:0]           wait_in [NM];

   // Scan progress.
   logic [MW-1:0]           row_ff, row_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    found_ff, found_in;
   logic [MW-1:0]           pair_a_ff, pair_a_in;
   logic [MW-1:0]           pair_b_ff, pair_b_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [mtx_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   // Shared row compare unit and finish-step decode.
   logic                    row_live;
   logic [TW-1:0]           row_holder;
   logic [NT-1:0]           row_wait;
   logic [NM-1:0]           pair_vec;
   logic [MW-1:0]           first_col;
   logic [CW:0]             count_sum;
   logic                    finish;
   logic                    id_ok;
   logic                    thread_ok;
   mtx_pkg::status_type     status;
   logic                    granted;
   logic [MW-1:0]           new_mutex;
   logic                    scanned;

   assign req_tready = (state_ff == SEQ_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The row under scan is compared against every higher row at once: a pair
   // counts when both mutexes are held by different threads and each holder
   // waits on the other's mutex.
   always_comb begin
      row_live   = (AW'(row_ff) < alloc_ff) && held_ff[row_ff];
      row_holder = holder_ff[row_ff];
      row_wait   = wait_ff[row_ff];
      for (int j = 0; j < NM; j++) begin
         pair_vec[j] = row_live && (MW'(j) > row_ff) && (AW'(j) < alloc_ff)
                       && held_ff[j] && (holder_ff[j] != row_holder)
                       && row_wait[holder_ff[j]] && wait_ff[j][row_holder];
      end
      first_col = '0;
      for (int j = NM - 1; j >= 0; j--) begin
         if (pair_vec[j]) begin
            first_col = MW'(j);
         end
      end
      count_sum = (CW + 1)'(count_ff) + (CW + 1)'($countones(pair_vec));
   end

   // Outcome of the captured command against the table as it stands.
   always_comb begin
      finish    = (state_ff == SEQ_DONE) && (!rsp_valid_ff || rsp_tready);
      id_ok     = (AW'(mutex_ff) < alloc_ff);
      thread_ok = ((TW + 1)'(thread_ff) < (TW + 1)'(NT));
      status    = mtx_pkg::STATUS_OK;
      granted   = 1'b0;
      new_mutex = '0;
      scanned   = 1'b0;
      case (cmd_ff)
         mtx_pkg::CMD_CREATE: begin
            if (alloc_ff >= AW'(NM)) begin
               status = mtx_pkg::STATUS_NO_SPACE;
            end else begin
               new_mutex = alloc_ff[MW-1:0];
            end
         end
         mtx_pkg::CMD_DESTROY: begin
            if (!id_ok) begin
               status = mtx_pkg::STATUS_BAD_ID;
            end else if (held_ff[mutex_ff]) begin
               status = mtx_pkg::STATUS_BUSY;
            end
         end
         mtx_pkg::CMD_LOCK: begin
            if (!id_ok || !thread_ok) begin
               status = mtx_pkg::STATUS_BAD_ID;
            end else begin
               scanned = 1'b1;
               granted = !held_ff[mutex_ff] || (holder_ff[mutex_ff] == thread_ff);
            end
         end
         mtx_pkg::CMD_UNLOCK: begin
            if (!id_ok || !thread_ok) begin
               status = mtx_pkg::STATUS_BAD_ID;
            end else if (!held_ff[mutex_ff] || holder_ff[mutex_ff] != thread_ff) begin
               status = mtx_pkg::STATUS_NOT_OWNER;
            end
         end
         default: begin
            status = mtx_pkg::STATUS_BAD_ID;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      mutex_in     = mutex_ff;
      thread_in    = thread_ff;
      alloc_in     = alloc_ff;
      held_in      = held_ff;
      holder_in    = holder_ff;
      wait_in      = wait_ff;
      row_in       = row_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      pair_a_in    = pair_a_ff;
      pair_b_in    = pair_b_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = mtx_pkg::cmd_type'(req_tdata[mtx_pkg::CmdW-1:0]);
               mutex_in  = req_tdata[mtx_pkg::CmdW +: MW];
               thread_in = req_tdata[mtx_pkg::CmdW + MW +: TW];
               row_in    = '0;
               count_in  = '0;
               found_in  = 1'b0;
               pair_a_in = '0;
               pair_b_in = '0;
               // Only a lock that passes the id checks is scanned.
               if (cmd_in == mtx_pkg::CMD_LOCK
                   && (AW'(mutex_in) < alloc_ff)
                   && ((TW + 1)'(thread_in) < (TW + 1)'(NT))) begin
                  state_in = SEQ_SCAN;
               end else begin
                  state_in = SEQ_DONE;
               end
            end
         end
         SEQ_SCAN: begin
            count_in = (count_sum > (CW + 1)'(mtx_pkg::CountSat))
                       ? CW'(mtx_pkg::CountSat) : count_sum[CW-1:0];
            if (!found_ff && (pair_vec != '0)) begin
               found_in  = 1'b1;
               pair_a_in = row_ff;
               pair_b_in = first_col;
            end
            row_in = row_ff + 1'b1;
            if (row_ff == MW'(NM - 1)) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (finish) begin
               state_in     = SEQ_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[mtx_pkg::RspStatusLo +: mtx_pkg::StatusW] = status;
               rsp_data_in[mtx_pkg::RspGrantedLo] = granted;
               rsp_data_in[mtx_pkg::RspNewLo +: MW] = new_mutex;
               if (scanned) begin
                  rsp_data_in[mtx_pkg::RspCountLo +: CW] = count_ff;
                  rsp_data_in[mtx_pkg::RspPairALo +: MW] = pair_a_ff;
                  rsp_data_in[mtx_pkg::RspPairBLo +: MW] = pair_b_ff;
               end
               case (cmd_ff)
                  mtx_pkg::CMD_CREATE: begin
                     if (status == mtx_pkg::STATUS_OK) begin
                        held_in[new_mutex] = 1'b0;
                        wait_in[new_mutex] = '0;
                        alloc_in           = alloc_ff + 1'b1;
                     end
                  end
                  mtx_pkg::CMD_LOCK: begin
                     if (scanned) begin
                        if (!held_ff[mutex_ff]) begin
                           held_in[mutex_ff]   = 1'b1;
                           holder_in[mutex_ff] = thread_ff;
                        end else if (!granted) begin
                           wait_in[mutex_ff][thread_ff] = 1'b1;
                        end
                     end
                  end
                  mtx_pkg::CMD_UNLOCK: begin
                     if (status == mtx_pkg::STATUS_OK) begin
                        held_in[mutex_ff] = 1'b0;
                        wait_in[mutex_ff] = '0;
                     end
                  end
                  default: begin
                     // Destroy never changes the table.
                  end
               endcase
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         alloc_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NM; i++) begin
            wait_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         alloc_ff     <= alloc_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_ff      <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      mutex_ff    <= mutex_in;
      thread_ff   <= thread_in;
      holder_ff   <= holder_in;
      row_ff      <= row_in;
      count_ff    <= count_in;
      found_ff    <= found_in;
      pair_a_ff   <= pair_a_in;
      pair_b_ff   <= pair_b_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hw/rtl/mtx_checker.sv -----
// ----------------------------------------------------------------------------
// mtx_checker
// Port-level checks of the mutex table core, bound to its top level.
// ----------------------------------------------------------------------------
module mtx_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [mtx_pkg::RspDataW-1:0] rsp_tdata
);

   localparam int MW = mtx_pkg::MutexW;

   // A stalled response word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // The core works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while a command was in progress");

   // A grant is only ever reported with an ok status.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[mtx_pkg::RspGrantedLo]
      |-> rsp_tdata[mtx_pkg::RspStatusLo +: mtx_pkg::StatusW] == mtx_pkg::STATUS_OK)
      else $error("grant with a failing status");

   // A reported pair is ordered, lower mutex first.
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[mtx_pkg::RspCountLo +: mtx_pkg::CountW] != '0
      |-> rsp_tdata[mtx_pkg::RspPairBLo +: MW] > rsp_tdata[mtx_pkg::RspPairALo +: MW])
      else $error("deadlocked pair out of order");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

bind mutex_table_with_deadlock_check_core mtx_checker u_mtx_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/mutex_table_checker.sv -----
// ----------------------------------------------------------------------------
// mutex_table_checker
// Watches both channels of the mutex table core, keeps a private copy of the
// lock table, predicts each response word and compares it field by field.
// ----------------------------------------------------------------------------
module mutex_table_checker
   import mtx_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RspDataW-1:0] rsp_tdata,
   output int                  fail_count,
   output int                  pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      status_type        status;
      logic              granted;
      logic [MutexW-1:0] new_mutex;
      logic [CountW-1:0] pair_count;
      logic [MutexW-1:0] pair_a;
      logic [MutexW-1:0] pair_b;
   } lock_reply_type;

   // Shadow lock table.
   int                 slots_used;
   logic               is_held   [MaxMutexes];
   logic [ThreadW-1:0] owner     [MaxMutexes];
   logic [MaxThreads-1:0] waiters [MaxMutexes];

   lock_reply_type replies_due[$];
   int             errors = 0;

   assign fail_count = errors;

   // Counts the held mutex pairs whose holders wait on each other's mutex.
   function automatic void count_mutual_waits(ref lock_reply_type r);
      int  n;
      logic found;
      n = 0;
      found = 1'b0;
      for (int i = 0; i < slots_used; i++) begin
         if (!is_held[i]) continue;
         for (int j = i + 1; j < slots_used; j++) begin
            if (!is_held[j] || owner[i] == owner[j]) continue;
            if (waiters[i][owner[j]] && waiters[j][owner[i]]) begin
               if (n < CountSat) n++;
               if (!found) begin
                  found = 1'b1;
                  r.pair_a = MutexW'(i);
                  r.pair_b = MutexW'(j);
               end
            end
         end
      end
      r.pair_count = CountW'(n);
   endfunction

   function automatic lock_reply_type apply_command(cmd_type cmd, int m, int t);
      lock_reply_type r;
      r = '{STATUS_OK, 1'b0, '0, '0, '0, '0};
      if (cmd == CMD_CREATE) begin
         if (slots_used >= MaxMutexes) begin
            r.status = STATUS_NO_SPACE;
         end else begin
            is_held[slots_used] = 1'b0;
            owner[slots_used]   = '0;
            waiters[slots_used] = '0;
            r.new_mutex = MutexW'(slots_used);
            slots_used++;
         end
      end else if (m >= slots_used) begin
         r.status = STATUS_BAD_ID;
      end else if (cmd == CMD_DESTROY) begin
         r.status = is_held[m] ? STATUS_BUSY : STATUS_OK;
      end else if (t >= MaxThreads) begin
         r.status = STATUS_BAD_ID;
      end else if (cmd == CMD_LOCK) begin
         count_mutual_waits(r);
         if (!is_held[m]) begin
            is_held[m] = 1'b1;
            owner[m]   = ThreadW'(t);
            r.granted  = 1'b1;
         end else if (owner[m] == ThreadW'(t)) begin
            r.granted = 1'b1;
         end else begin
            waiters[m][t] = 1'b1;
         end
      end else if (!is_held[m] || owner[m] != ThreadW'(t)) begin
         r.status = STATUS_NOT_OWNER;
      end else begin
         is_held[m] = 1'b0;
         owner[m]   = '0;
         waiters[m] = '0;
      end
      return r;
   endfunction

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      lock_reply_type want;
      if (reset) begin
         slots_used = 0;
         for (int i = 0; i < MaxMutexes; i++) begin
            is_held[i] = 1'b0;
            owner[i]   = '0;
            waiters[i] = '0;
         end
         replies_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (replies_due.size() == 0) begin
               errors++;
               $display("%0t ns: response word 0x%h with nothing expected, expected none",
                        $time, rsp_tdata);
            end else begin
               want = replies_due.pop_front();
               check_field("status", 8'(want.status), 8'(rsp_tdata[RspStatusLo +: StatusW]));
               check_field("granted", 8'(want.granted), 8'(rsp_tdata[RspGrantedLo]));
               check_field("new_mutex", 8'(want.new_mutex),
                           8'(rsp_tdata[RspNewLo +: MutexW]));
               check_field("deadlock_count", 8'(want.pair_count),
                           8'(rsp_tdata[RspCountLo +: CountW]));
               check_field("first_pair_a", 8'(want.pair_a), 8'(rsp_tdata[RspPairALo +: MutexW]));
               check_field("first_pair_b", 8'(want.pair_b), 8'(rsp_tdata[RspPairBLo +: MutexW]));
               check_field("padding", 8'd0, 8'(rsp_tdata[RspDataW-1:RspFieldW]));
            end
         end
         if (req_tvalid && req_tready) begin
            replies_due.push_back(apply_command(cmd_type'(req_tdata[CmdW-1:0]),
                                                int'(req_tdata[CmdW +: MutexW]),
                                                int'(req_tdata[CmdW+MutexW +: ThreadW])));
         end
      end
      pending <= replies_due.size();
   end

endmodule

// ----- tb/tb_mutex_table_with_deadlock_check_core.sv -----
// ----------------------------------------------------------------------------
// tb_mutex_table_with_deadlock_check_core
// Drives command words into the mutex table core under several idling and
// stalling patterns and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_mutex_table_with_deadlock_check_core;

   timeunit 1ns;
   timeprecision 1ps;

   import mtx_pkg::*;

   // Watchdog limit on the whole run.
   localparam int CycleLimit  = 400000;
   // Covers any word still in flight when the drain ends.
   localparam int DrainCycles = 40;
   localparam int PhaseWords  = 413;
   localparam int HoldCycles  = 300;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   int fail_count;
   int pending;

   // Stimulus knobs, in percent of cycles.
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   // Toggling this asks the response side for one long hold-off.
   logic hold_toggle   = 1'b0;
   logic hold_seen     = 1'b0;
   int   hold_left     = 0;

   int words_sent   = 0;
   int creates_sent = 0;
   int cycle_count  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mutex_table_with_deadlock_check_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   mutex_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Response side. A hold-off request drops ready for a long stretch so the
   // core fills its output register and sequencer and stops taking words;
   // otherwise ready stalls at random with the current probability.
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= HoldCycles;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Offers one command word and returns at the edge where it is taken. The
   // valid stays high into the next call, so back-to-back words need no gap.
   task automatic send_word(cmd_type cmd, logic [MutexW-1:0] m, logic [ThreadW-1:0] t);
      logic [ReqDataW-1:0] w;
      w = '0;
      w[CmdW-1:0]                = cmd;
      w[CmdW +: MutexW]          = m;
      w[CmdW+MutexW +: ThreadW]  = t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      if (cmd == CMD_CREATE) creates_sent++;
   endtask

   // Stops offering and waits until every response word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // A few threads share most of the traffic so that they collide often.
   function automatic logic [ThreadW-1:0] pick_thread();
      if ($urandom_range(99) < 70) return ThreadW'($urandom_range(3));
      return ThreadW'($urandom_range(MaxThreads - 1));
   endfunction

   // Mostly allocated mutexes; now and then any index, which hits bad_id
   // while the table is still filling.
   function automatic logic [MutexW-1:0] pick_mutex();
      int top;
      top = (creates_sent >= MaxMutexes) ? MaxMutexes : creates_sent;
      if (top == 0 || $urandom_range(99) < 5) return MutexW'($urandom_range(MaxMutexes - 1));
      return MutexW'($urandom_range(top - 1));
   endfunction

   task automatic send_random_word();
      int      roll;
      cmd_type cmd;
      roll = $urandom_range(99);
      if (roll < 12)      cmd = CMD_CREATE;
      else if (roll < 67) cmd = CMD_LOCK;
      else if (roll < 92) cmd = CMD_UNLOCK;
      else                cmd = CMD_DESTROY;
      send_word(cmd, pick_mutex(), pick_thread());
   endtask

   // Two threads each take a mutex and then ask for the other's one, which
   // sets up a mutual wait; a further lock lets the scan report it, and the
   // round may end by releasing both mutexes.
   task automatic send_crossed_locks();
      logic [MutexW-1:0]  ma, mb;
      logic [ThreadW-1:0] ta, tb;
      ma = pick_mutex();
      mb = pick_mutex();
      ta = pick_thread();
      tb = pick_thread();
      if (ta == tb) tb = ta + 1'b1;
      send_word(CMD_LOCK, ma, ta);
      send_word(CMD_LOCK, mb, tb);
      send_word(CMD_LOCK, mb, ta);
      send_word(CMD_LOCK, ma, tb);
      send_word(CMD_LOCK, pick_mutex(), pick_thread());
      if ($urandom_range(1) == 1) begin
         send_word(CMD_UNLOCK, ma, ta);
         send_word(CMD_UNLOCK, mb, tb);
      end
   endtask

   task automatic run_random_phase(int idle_pct, int stall_pct, logic with_hold);
      int target;
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      if (with_hold) hold_toggle <= ~hold_toggle;
      target = words_sent + PhaseWords;
      while (words_sent < target) begin
         if (creates_sent > 1 && $urandom_range(99) < 45) send_crossed_locks();
         else send_random_word();
      end
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Commands on an empty table are refused as bad ids.
      send_word(CMD_LOCK,    4'd0,  4'd0);
      send_word(CMD_UNLOCK,  4'd15, 4'd15);
      send_word(CMD_DESTROY, 4'd15, 4'd0);
      repeat (4) send_word(CMD_CREATE, 4'd15, 4'd15);
      // Grant, grant again to the same holder, then two threads cross.
      send_word(CMD_LOCK,    4'd0,  4'd1);
      send_word(CMD_LOCK,    4'd0,  4'd1);
      send_word(CMD_LOCK,    4'd1,  4'd2);
      send_word(CMD_LOCK,    4'd1,  4'd1);
      send_word(CMD_LOCK,    4'd0,  4'd2);
      // The scan before this lock sees the mutual wait on mutexes 0 and 1.
      send_word(CMD_LOCK,    4'd2,  4'd15);
      send_word(CMD_LOCK,    4'd3,  4'd15);
      send_word(CMD_LOCK,    4'd2,  4'd14);
      // Unlock by a non-holder and of a mutex held by someone else.
      send_word(CMD_UNLOCK,  4'd0,  4'd2);
      send_word(CMD_UNLOCK,  4'd3,  4'd0);
      send_word(CMD_DESTROY, 4'd1,  4'd0);
      send_word(CMD_UNLOCK,  4'd3,  4'd15);
      // Destroying a free mutex leaves the slot usable.
      send_word(CMD_DESTROY, 4'd3,  4'd0);
      send_word(CMD_LOCK,    4'd3,  4'd0);
      // Releasing mutex 0 clears its waiters, so the pair is gone.
      send_word(CMD_UNLOCK,  4'd0,  4'd1);
      send_word(CMD_LOCK,    4'd1,  4'd1);
      send_word(CMD_LOCK,    4'd7,  4'd3);
      wait_drained();

      // Random part; each phase ends with the sender paused until the core
      // has returned every word.
      run_random_phase(0, 0, 1'b1);
      run_random_phase(87, 0, 1'b0);
      run_random_phase(0, 87, 1'b0);
      run_random_phase(31, 31, 1'b0);

      rsp_stall_pct <= 0;
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
